// ===== hdl/ogd_pkg.sv =====
// Shared types and constants for the occupancy grid dilation block.
// No dependencies; used by every module in hdl/.
`default_nettype none

package ogd_pkg;

   localparam int CELL_BITS        = 8;
   localparam int GRID_WIDTH_BITS  = 11;
   localparam int GRID_HEIGHT_BITS = 16;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 11'd256;
   localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 16'd256;
   localparam int MIN_DIM = 3;

   localparam logic [CELL_BITS-1:0] OBSTACLE = 8'd100;

   // register index, taken from paddr[2]
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // req tuser action code
   localparam logic ACTION_CELL  = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // control for one window shift, from the input stage to the window
   typedef struct packed {
      logic data;      // column comes from the line stores and the input cell, else zeros
      logic have_out;  // shift produces a result
      logic border;    // result cell lies on the frame border
      logic last;      // result is the last cell of the frame
   } ogd_stage_type;

endpackage

`default_nettype wire

// ===== hdl/ogd_line_buf.sv =====
// Two row stores (upper and middle) with registered read data.
// Depends on ogd_pkg for the cell width.
`default_nettype none

module ogd_line_buf #(
   parameter int MAX_WIDTH = ogd_pkg::MAX_WIDTH_DEFAULT,
   parameter int ADDR_BITS = $clog2(MAX_WIDTH)
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_BITS-1:0]          rd_addr,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_BITS-1:0]          wr_addr,
   input  wire logic [ogd_pkg::CELL_BITS-1:0] wr_cell,
   output logic      [ogd_pkg::CELL_BITS-1:0] rd_upper,
   output logic      [ogd_pkg::CELL_BITS-1:0] rd_middle
);

   logic [ogd_pkg::CELL_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [ogd_pkg::CELL_BITS-1:0] middle_mem [MAX_WIDTH];
   logic [ogd_pkg::CELL_BITS-1:0] rd_upper_ff;
   logic [ogd_pkg::CELL_BITS-1:0] rd_middle_ff;

   // the middle row moves up, the new cell takes its place
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= rd_middle_ff;
         middle_mem[wr_addr] <= wr_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

`default_nettype wire

// ===== hdl/ogd_window.sv =====
// 3x3 window registers and the 8-neighbour obstacle test.
// Depends on ogd_pkg for the stage control struct and constants.
`default_nettype none

module ogd_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift,
   input  wire ogd_pkg::ogd_stage_type        ctrl,
   input  wire logic [ogd_pkg::CELL_BITS-1:0] col_top,
   input  wire logic [ogd_pkg::CELL_BITS-1:0] col_mid,
   input  wire logic [ogd_pkg::CELL_BITS-1:0] col_bot,
   output logic      [ogd_pkg::CELL_BITS-1:0] result
);

   logic [ogd_pkg::CELL_BITS-1:0] window_ff [3][3];
   logic [ogd_pkg::CELL_BITS-1:0] window_in [3][3];
   logic [ogd_pkg::CELL_BITS-1:0] column [3];
   logic                          hit;

   always_comb begin
      column[0] = ctrl.data ? col_top : '0;
      column[1] = ctrl.data ? col_mid : '0;
      column[2] = ctrl.data ? col_bot : '0;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
         window_in[r][2] = column[r];
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1) && window_in[r][c] == ogd_pkg::OBSTACLE) begin
               hit = 1'b1;
            end
         end
      end
      result = (!ctrl.border && hit) ? ogd_pkg::OBSTACLE : window_in[1][1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else if (shift) begin
         window_ff <= window_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/occupancy_grid_dilation.sv =====
// Top level of the occupancy grid dilation block: stream ports, CSRs, input stage.
// Depends on ogd_pkg, ogd_line_buf and ogd_window.
//
// Takes one occupancy cell per clock in raster order while the result stream is not stalled and
// returns each cell after one pass of 8-neighbour obstacle growth: an interior cell becomes 100
// when any neighbour is 100, border cells pass unchanged. A transfer can be taken every cycle
// unless the result register stalls; throughput is then one cell per clock, set by the row
// stores, which take one read and one write per cell. An item passes two register stages
// (input stage with the row-store read, then window logic into the result register); a stalled
// result register holds the input stage and with it req_tready. Results trail the input by one
// row plus one cell, so a frame needs width+1 drain transfers (tuser = 1) after its last cell;
// drain transfers sent earlier are dropped.
// tlast marks the frame's last cell. Writing grid_width or grid_height restarts the frame;
// write them only while the block is empty. grid_width is clamped to 3..MAX_WIDTH and
// grid_height to at least 3; reads return the raw values.
`default_nettype none

module occupancy_grid_dilation #(
   parameter int MAX_WIDTH = ogd_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] cell_value
   input  wire logic [0:0]                        req_tuser,   // [0] action
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [7:0]                        rsp_tdata,   // [7:0] out_value
   output logic                                   rsp_tlast,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ogd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [ogd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [ogd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int COL_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int WB        = ogd_pkg::GRID_WIDTH_BITS;
   localparam int HB        = ogd_pkg::GRID_HEIGHT_BITS;
   localparam int CB        = ogd_pkg::CELL_BITS;

   // registers
   logic [WB-1:0]       grid_width_ff;
   logic [HB-1:0]       grid_height_ff;
   logic [COL_BITS-1:0] width_eff_ff,  width_eff_in;
   logic [HB-1:0]       height_eff_ff, height_eff_in;
   logic                csr_we;
   logic [31:0]         wr_width32;

   // position counters
   logic [COL_BITS-1:0] col_ff, col_in, col_plus;
   logic [HB-1:0]       row_ff, row_in;

   // input stage
   logic                   valid_a_ff;
   ogd_pkg::ogd_stage_type stage_a_ff, stage_a_in;
   logic [CB-1:0]          cell_a_ff;
   logic [ADDR_BITS-1:0]   addr_a_ff;

   // result register
   logic          rsp_valid_ff;
   logic [CB-1:0] rsp_value_ff;
   logic          rsp_last_ff;

   logic          accept, data_phase, drain_in, load_a, adv_a, rd_en;
   logic [CB-1:0] rd_upper, rd_middle, result;

   // ---------------- CSRs ----------------
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      wr_width32 = 32'(csr_pwdata[WB-1:0]);
      if (wr_width32 < 32'(ogd_pkg::MIN_DIM)) begin
         width_eff_in = COL_BITS'(ogd_pkg::MIN_DIM);
      end else if (wr_width32 > 32'(MAX_WIDTH)) begin
         width_eff_in = COL_BITS'(MAX_WIDTH);
      end else begin
         width_eff_in = COL_BITS'(wr_width32);
      end
      if (csr_pwdata[HB-1:0] < HB'(ogd_pkg::MIN_DIM)) begin
         height_eff_in = HB'(ogd_pkg::MIN_DIM);
      end else begin
         height_eff_in = csr_pwdata[HB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= ogd_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= ogd_pkg::GRID_HEIGHT_RESET;
         width_eff_ff   <= (32'(ogd_pkg::GRID_WIDTH_RESET) > 32'(MAX_WIDTH)) ?
                           COL_BITS'(MAX_WIDTH) : COL_BITS'(ogd_pkg::GRID_WIDTH_RESET);
         height_eff_ff  <= ogd_pkg::GRID_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_paddr[2])
            ogd_pkg::REG_GRID_WIDTH: begin
               grid_width_ff <= csr_pwdata[WB-1:0];
               width_eff_ff  <= width_eff_in;
            end
            ogd_pkg::REG_GRID_HEIGHT: begin
               grid_height_ff <= csr_pwdata[HB-1:0];
               height_eff_ff  <= height_eff_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ogd_pkg::REG_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         ogd_pkg::REG_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------- input side ----------------
   assign accept     = req_tvalid & req_tready;
   assign data_phase = row_ff < height_eff_ff;
   assign drain_in   = req_tuser[0] == ogd_pkg::ACTION_DRAIN;
   assign load_a     = accept & ~(data_phase & drain_in);
   assign rd_en      = accept & data_phase & ~drain_in;

   assign adv_a      = valid_a_ff & (~stage_a_ff.have_out | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~valid_a_ff | adv_a;

   always_comb begin
      col_plus = col_ff + COL_BITS'(1);

      stage_a_in.data     = data_phase;
      stage_a_in.have_out = 1'b0;
      stage_a_in.border   = 1'b0;
      stage_a_in.last     = 1'b0;
      if (col_ff != '0 && row_ff != '0) begin
         stage_a_in.have_out = 1'b1;
         stage_a_in.border   = (row_ff == HB'(1)) || !data_phase ||
                               (col_ff == COL_BITS'(1)) || (col_ff >= width_eff_ff);
         stage_a_in.last     = !data_phase && (col_ff == width_eff_ff);
      end else if (col_ff == '0 && row_ff > HB'(1)) begin
         stage_a_in.have_out = 1'b1;
         stage_a_in.border   = 1'b1;
      end

      col_in = col_plus;
      row_in = row_ff;
      if (data_phase && col_plus >= width_eff_ff) begin
         col_in = '0;
         row_in = row_ff + HB'(1);
      end
      if (stage_a_in.last) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         valid_a_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (load_a) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (load_a) begin
            valid_a_ff <= 1'b1;
         end else if (adv_a) begin
            valid_a_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         stage_a_ff <= stage_a_in;
         cell_a_ff  <= req_tdata[CB-1:0];
         addr_a_ff  <= col_ff[ADDR_BITS-1:0];
      end
   end

   ogd_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_line_buf (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr   (col_ff[ADDR_BITS-1:0]),
      .wr_en     (adv_a & stage_a_ff.data),
      .wr_addr   (addr_a_ff),
      .wr_cell   (cell_a_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   ogd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .shift   (adv_a),
      .ctrl    (stage_a_ff),
      .col_top (rd_upper),
      .col_mid (rd_middle),
      .col_bot (cell_a_ff),
      .result  (result)
   );

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_a && stage_a_ff.have_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && stage_a_ff.have_out) begin
         rsp_value_ff <= result;
         rsp_last_ff  <= stage_a_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/occupancy_grid_dilation_test.sv =====
// Self-checking testbench for occupancy_grid_dilation: drives cell and drain transfers with
// random gaps and stalls, predicts each dilated cell and checks it on the result stream.
// Depends on ogd_pkg and the RTL in hdl/.
`default_nettype none

module occupancy_grid_dilation_test;

   localparam int MAX_W          = ogd_pkg::MAX_WIDTH_DEFAULT;
   localparam int CB             = ogd_pkg::CELL_BITS;
   localparam int ITEM_TARGET    = 550;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [CB-1:0] value;
      logic          last;
   } grid_result_type;

   class dilation_scoreboard_type;
      bit [ogd_pkg::GRID_WIDTH_BITS-1:0]  width_reg;
      bit [ogd_pkg::GRID_HEIGHT_BITS-1:0] height_reg;
      bit [CB-1:0]                        upper_row [MAX_W];
      bit [CB-1:0]                        middle_row [MAX_W];
      bit [CB-1:0]                        win [3][3];
      int unsigned                        col, row, emitted;
      grid_result_type                    dilated_q [$];
      int                                 errors, checked;

      function new();
         width_reg  = ogd_pkg::GRID_WIDTH_RESET;
         height_reg = ogd_pkg::GRID_HEIGHT_RESET;
         errors     = 0;
         checked    = 0;
         rewind();
      endfunction

      function void rewind();
         col     = 0;
         row     = 0;
         emitted = 0;
      endfunction

      function int unsigned eff_w();
         if (width_reg < ogd_pkg::MIN_DIM) return ogd_pkg::MIN_DIM;
         if (width_reg > MAX_W) return MAX_W;
         return 32'(width_reg);
      endfunction

      function int unsigned eff_h();
         return (height_reg < ogd_pkg::MIN_DIM) ? ogd_pkg::MIN_DIM : 32'(height_reg);
      endfunction

      function void write_reg(logic idx, logic [ogd_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == ogd_pkg::REG_GRID_WIDTH) width_reg = data[ogd_pkg::GRID_WIDTH_BITS-1:0];
         else height_reg = data[ogd_pkg::GRID_HEIGHT_BITS-1:0];
         rewind();
      endfunction

      function void slide_window(bit [CB-1:0] top, bit [CB-1:0] mid, bit [CB-1:0] bot);
         for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = bot;
      endfunction

      function bit [CB-1:0] grow_centre();
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               if ((r != 1 || c != 1) && win[r][c] == ogd_pkg::OBSTACLE)
                  return ogd_pkg::OBSTACLE;
         return win[1][1];
      endfunction

      function void note_input(logic act, logic [CB-1:0] cell_val);
         int unsigned     w, h, r, c, orow, ocol;
         bit [CB-1:0]     top, mid, val;
         bit              emit, fin;
         grid_result_type res;
         w    = eff_w();
         h    = eff_h();
         r    = row;
         c    = col;
         emit = 0;
         orow = 0;
         ocol = 0;
         if (r < h) begin
            // drain while cells are still due: dropped
            if (act == ogd_pkg::ACTION_DRAIN) return;
            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = cell_val;
            slide_window(top, mid, cell_val);
         end else begin
            slide_window('0, '0, '0);
         end
         if (c >= 1 && r >= 1) begin
            emit = 1;
            orow = r - 1;
            ocol = c - 1;
         end else if (c == 0 && r >= 2) begin
            emit = 1;
            orow = r - 2;
            ocol = w - 1;
         end
         c++;
         if (r < h && c >= w) begin
            c = 0;
            r++;
         end
         col = c;
         row = r;
         if (!emit) return;
         if (orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w) val = win[1][1];
         else val = grow_centre();
         emitted++;
         fin = (emitted >= w * h);
         res.value = val;
         res.last  = fin;
         dilated_q.insert(dilated_q.size(), res);
         if (fin) rewind();
      endfunction

      function void check_result(logic [CB-1:0] value, logic last);
         grid_result_type want;
         if (dilated_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got value %0d last %0b",
                     $time, $signed(value), last);
            return;
         end
         want = dilated_q.pop_front();
         checked++;
         if (value !== want.value) begin
            errors++;
            $display("%0t: out_value mismatch, expected %0d, got %0d",
                     $time, $signed(want.value), $signed(value));
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: frame_last mismatch, expected %0b, got %0b", $time, want.last, last);
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [7:0]                           req_tdata;   // [7:0] cell_value
   logic [0:0]                           req_tuser;   // [0] action
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic [7:0]                           rsp_tdata;   // [7:0] out_value
   logic                                 rsp_tlast;
   logic                                 csr_psel;
   logic                                 csr_penable;
   logic                                 csr_pwrite;
   logic [ogd_pkg::CSR_ADDR_BITS-1:0]    csr_paddr;
   logic [ogd_pkg::CSR_DATA_BITS-1:0]    csr_pwdata;
   logic [ogd_pkg::CSR_DATA_BITS-1:0]    csr_prdata;
   logic                                 csr_pready;

   dilation_scoreboard_type board = new();

   int send_mode   = 0;
   int stall_mode  = 0;
   int stall_left  = 0;
   int quiet_count = 0;
   int counted     = 0;
   int cells_sent  = 0;
   int drains_sent = 0;
   int frames_full = 0;
   int frames_cut  = 0;
   int cur_w_raw   = int'(ogd_pkg::GRID_WIDTH_RESET);
   int cur_h_raw   = int'(ogd_pkg::GRID_HEIGHT_RESET);

   occupancy_grid_dilation dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap(int mode);
      int r;
      if (mode == 0) return 0;
      r = $urandom_range(0, 19);
      if (r < 14) return 1 + $urandom_range(0, 2);
      if (r < 18) return $urandom_range(4, 8);
      return (mode == 2) ? $urandom_range(20, 60) : $urandom_range(4, 10);
   endfunction

   function automatic logic [7:0] random_cell();
      case ($urandom_range(0, 9))
         0, 1, 2: return ogd_pkg::OBSTACLE;
         3: return 8'hFF;
         4: return 8'd0;
         9: return 8'($urandom);
         default: return 8'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic int clamp_w(int raw);
      if (raw < ogd_pkg::MIN_DIM) return ogd_pkg::MIN_DIM;
      return (raw > MAX_W) ? MAX_W : raw;
   endfunction

   function automatic int clamp_h(int raw);
      return (raw < ogd_pkg::MIN_DIM) ? ogd_pkg::MIN_DIM : raw;
   endfunction

   // transfer monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_input(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            board.write_reg(csr_paddr[2], csr_pwdata);
      end
   end

   // result-side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap(stall_mode) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // entered and left at a falling edge
   task automatic send_item(input logic act, input logic [7:0] cell_val);
      int gap;
      gap = (send_mode != 0 && $urandom_range(0, 3) == 0) ? pick_gap(send_mode) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= cell_val;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (act == ogd_pkg::ACTION_DRAIN) drains_sent++;
      else cells_sent++;
   endtask

   task automatic release_input();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.dilated_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic idx, input logic wr, input logic [31:0] data,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wr ? data : '0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic idx, input int want);
      logic [31:0] got;
      csr_access(idx, 1'b0, '0, got);
      if (got !== 32'(want)) begin
         board.errors++;
         $display("%0t: register %0d read, expected %0d, got %0d", $time, idx, want, got);
      end
   endtask

   task automatic set_grid(input bit do_w, input int w_raw, input bit do_h, input int h_raw);
      logic [31:0] unused;
      release_input();
      wait_drained();
      if (do_w) begin
         cur_w_raw = w_raw & 'h7FF;
         csr_access(ogd_pkg::REG_GRID_WIDTH, 1'b1, 32'(cur_w_raw), unused);
         csr_check(ogd_pkg::REG_GRID_WIDTH, cur_w_raw);
      end
      if (do_h) begin
         cur_h_raw = h_raw & 'hFFFF;
         csr_access(ogd_pkg::REG_GRID_HEIGHT, 1'b1, 32'(cur_h_raw), unused);
         csr_check(ogd_pkg::REG_GRID_HEIGHT, cur_h_raw);
      end
   endtask

   // cut_at < 0 sends the whole frame and its drains
   task automatic run_frame(input int cut_at, input bit noisy);
      int w, h, total, pause_at;
      w     = clamp_w(cur_w_raw);
      h     = clamp_h(cur_h_raw);
      total = w * h;
      if (cut_at >= 0 && cut_at < total) total = cut_at;
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
      for (int n = 0; n < total; n++) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_item(ogd_pkg::ACTION_DRAIN, 8'($urandom));
         if (n == pause_at) begin
            release_input();
            wait_drained();
         end
         send_item(ogd_pkg::ACTION_CELL, random_cell());
         counted++;
      end
      if (total < w * h) begin
         frames_cut++;
      end else begin
         // tail flush; a cell sent now counts as drain
         for (int n = 0; n <= w; n++) begin
            if (noisy && $urandom_range(0, 3) == 0)
               send_item(ogd_pkg::ACTION_CELL, 8'($urandom));
            else send_item(ogd_pkg::ACTION_DRAIN, 8'($urandom));
            counted++;
         end
         if (noisy && $urandom_range(0, 2) == 0)
            send_item(ogd_pkg::ACTION_DRAIN, 8'($urandom));
         frames_full++;
      end
   endtask

   logic [7:0] demo_cells [12] = '{8'd100, 8'hFF, 8'd0, 8'd127,
                                   8'h80,  8'd0,  8'd50, 8'hFF,
                                   8'd0,   8'd0,  8'd0, 8'd99};

   initial begin
      int w, h;
      bit do_w, do_h;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ogd_pkg::ACTION_CELL;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_check(ogd_pkg::REG_GRID_WIDTH, int'(ogd_pkg::GRID_WIDTH_RESET));
      csr_check(ogd_pkg::REG_GRID_HEIGHT, int'(ogd_pkg::GRID_HEIGHT_RESET));

      // hand-built 4x3 frame, height clamped up from zero
      send_mode  = 1;
      stall_mode = 1;
      set_grid(1, 4, 1, 0);
      send_item(ogd_pkg::ACTION_DRAIN, 8'hA5);
      foreach (demo_cells[i]) send_item(ogd_pkg::ACTION_CELL, demo_cells[i]);
      send_item(ogd_pkg::ACTION_DRAIN, 8'h00);
      send_item(ogd_pkg::ACTION_CELL, 8'd100);
      repeat (3) send_item(ogd_pkg::ACTION_DRAIN, 8'hFF);
      frames_full++;

      // widest row, width clamped down, aborted part way along the first row
      send_mode  = 0;
      stall_mode = 2;
      set_grid(1, 2047, 1, 3);
      run_frame(150, 0);

      // tallest frame, aborted after a few rows by the next write
      send_mode = 2;
      set_grid(1, 1, 1, 65535);
      run_frame(20, 0);
      set_grid(1, 2, 1, 2);
      run_frame(-1, 1);

      while (counted < ITEM_TARGET) begin
         send_mode  = $urandom_range(0, 2);
         stall_mode = $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(0, 2);
            h = $urandom_range(0, 2);
         end else begin
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 6);
         end
         case ($urandom_range(0, 5))
            0: begin do_w = 1; do_h = 0; end
            1: begin do_w = 0; do_h = 1; end
            2: begin do_w = 0; do_h = 0; end
            default: begin do_w = 1; do_h = 1; end
         endcase
         if (do_w || do_h) set_grid(do_w, w, do_h, h);
         if ($urandom_range(0, 9) == 0) begin
            run_frame($urandom_range(1, clamp_w(cur_w_raw) * clamp_h(cur_h_raw) - 1),
                      $urandom_range(0, 2) == 0);
            set_grid(1, cur_w_raw, 0, 0);
         end else begin
            run_frame(-1, $urandom_range(0, 2) == 0);
         end
      end

      release_input();
      wait_drained();
      repeat (20) @(negedge clock);
      $display("Covered %0d whole and %0d aborted frames, clamped sizes, stray and late drains;",
               frames_full, frames_cut);
      $display("%0d cell and %0d drain transfers sent, %0d results checked, %0d errors.",
               cells_sent, drains_sent, board.checked, board.errors);
      if (board.dilated_q.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, board.dilated_q.size());
      if (board.errors == 0 && board.dilated_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
